// File: design/life_pkg.sv
// Shared types and constants of the Game of Life next-state unit.
`default_nettype none
package life_pkg;

    localparam int MAX_DIM  = 64;
    localparam int MIN_DIM  = 3;
    localparam int POS_W    = 6;                    // col and row field width
    localparam int DIM_W    = 7;                    // frame_width / frame_height width
    localparam int ADDR_W   = 2 * POS_W;
    localparam int CELLS    = MAX_DIM * MAX_DIM;
    localparam int PIX_W    = 32;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    localparam logic [CNT_W-1:0] BIRTH_COUNT  = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_LOW  = CNT_W'(2);
    localparam logic [CNT_W-1:0] SURVIVE_HIGH = CNT_W'(3);

    localparam logic [DIM_W-1:0] DIM_LOW    = DIM_W'(MIN_DIM);
    localparam logic [DIM_W-1:0] DIM_HIGH   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(64);
    localparam logic [PIX_W-1:0] LIVE_RESET = 32'hFFFF_FFFF;
    localparam logic [PIX_W-1:0] DEAD_RESET = 32'h0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_LIVE_COLOR   = 2'd2,
        REG_DEAD_COLOR   = 2'd3
    } cfg_reg_t;

    localparam logic KIND_STORE   = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    // clamp a frame dimension into the supported range
    function automatic logic [DIM_W-1:0] dim_in_use(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_LOW)
            r = DIM_LOW;
        else if (v > DIM_HIGH)
            r = DIM_HIGH;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/life_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface life_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [life_pkg::POS_W-1:0]  col;
    logic [life_pkg::POS_W-1:0]  row;
    logic [life_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, kind, col, row, pixel, input ready);
    modport sink   (input valid, kind, col, row, pixel, output ready);
endinterface

interface life_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [life_pkg::PIX_W-1:0]  next_pixel;
    logic                        next_alive;
    logic [life_pkg::CNT_W-1:0]  live_neighbours;

    modport source (output valid, next_pixel, next_alive, live_neighbours, input ready);
    modport sink   (input valid, next_pixel, next_alive, live_neighbours, output ready);
endinterface
`default_nettype wire

// File: design/life_next_state_toroidal.sv
// Game of Life B3/S23 next-state unit on a toroidal frame held in one cell memory.
//
// The frame is a 64 x 64 single-bit memory with a registered synchronous read.
// A store transfer writes one cell; when col and row lie inside the frame in
// use the write happens in the accept cycle, otherwise the address is first
// reduced modulo the frame size by a 6-step shift-subtract unit and written in
// the cycle after the last step. A compute transfer reads the nine cells of
// the 3x3 window through the single read port, one per cycle, then collects
// the last read in a drain state and loads the result register in a result
// state, then returns to ready. A result waits in its output register while
// the next command is taken; only a compute that finishes while the previous
// result is still untaken holds. Cells never stored since reset read as
// garbage. Configuration writes are taken any time and must happen only
// while the block is idle.
`default_nettype none
module life_next_state_toroidal (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [life_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [life_pkg::CFG_W-1:0]        cfg_data,
    life_cmd_if.sink                               cmd,
    life_rsp_if.source                             rsp
);

    localparam int POS_W  = life_pkg::POS_W;
    localparam int DIM_W  = life_pkg::DIM_W;
    localparam int ADDR_W = life_pkg::ADDR_W;
    localparam int PIX_W  = life_pkg::PIX_W;
    localparam int CNT_W  = life_pkg::CNT_W;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [PIX_W-1:0] live_color_reg;
    logic [PIX_W-1:0] dead_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= life_pkg::DIM_RESET;
            height_reg     <= life_pkg::DIM_RESET;
            live_color_reg <= life_pkg::LIVE_RESET;
            dead_color_reg <= life_pkg::DEAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                life_pkg::REG_FRAME_WIDTH:  width_reg      <= cfg_data[DIM_W-1:0];
                life_pkg::REG_FRAME_HEIGHT: height_reg     <= cfg_data[DIM_W-1:0];
                life_pkg::REG_LIVE_COLOR:   live_color_reg <= cfg_data[PIX_W-1:0];
                life_pkg::REG_DEAD_COLOR:   dead_color_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_use;
    logic [DIM_W-1:0] h_use;

    assign w_use = life_pkg::dim_in_use(width_reg);
    assign h_use = life_pkg::dim_in_use(height_reg);

    // control and datapath registers
    life_pkg::state_t state_reg, state_next;
    logic             kind_reg, kind_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_rem_reg, col_rem_next;
    logic [POS_W-1:0] row_rem_reg, row_rem_next;
    logic [2:0]       red_cnt_reg, red_cnt_next;
    logic             live_bit_reg, live_bit_next;
    logic [1:0]       rsel_reg, rsel_next;
    logic [1:0]       csel_reg, csel_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_self_reg, rd_self_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             self_reg, self_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pixel_reg, out_pixel_next;
    logic             out_alive_reg, out_alive_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    // cell memory
    logic              mem [life_pkg::CELLS];
    logic              rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // one shift-subtract step of col % w and row % h
    logic [DIM_W-1:0] col_trial;
    logic [DIM_W-1:0] row_trial;
    logic [POS_W-1:0] col_step;
    logic [POS_W-1:0] row_step;

    always_comb
    begin
        col_trial = {col_rem_reg, col_reg[POS_W-1]};
        row_trial = {row_rem_reg, row_reg[POS_W-1]};
        col_step  = (col_trial >= w_use) ? POS_W'(col_trial - w_use) : col_trial[POS_W-1:0];
        row_step  = (row_trial >= h_use) ? POS_W'(row_trial - h_use) : row_trial[POS_W-1:0];
    end

    // wrapped neighbour coordinates
    logic [POS_W-1:0] col_left, col_right, row_up, row_down;
    logic [POS_W-1:0] col_pick, row_pick;

    always_comb
    begin
        col_left  = (col_reg == '0) ? POS_W'(w_use - 1'b1) : POS_W'(col_reg - 1'b1);
        col_right = ((DIM_W'(col_reg) + 1'b1) == w_use) ? '0 : POS_W'(col_reg + 1'b1);
        row_up    = (row_reg == '0) ? POS_W'(h_use - 1'b1) : POS_W'(row_reg - 1'b1);
        row_down  = ((DIM_W'(row_reg) + 1'b1) == h_use) ? '0 : POS_W'(row_reg + 1'b1);
        case (csel_reg)
            2'd0:    col_pick = col_left;
            2'd1:    col_pick = col_reg;
            default: col_pick = col_right;
        endcase
        case (rsel_reg)
            2'd0:    row_pick = row_up;
            2'd1:    row_pick = row_reg;
            default: row_pick = row_down;
        endcase
    end

    logic cmd_fire;
    logic in_range;
    logic pix_live;
    logic out_free;
    logic alive;

    assign cmd.ready = (state_reg == life_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign in_range  = (DIM_W'(cmd.col) < w_use) && (DIM_W'(cmd.row) < h_use);
    assign pix_live  = (cmd.pixel == live_color_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (self_reg)
            alive = (count_reg >= life_pkg::SURVIVE_LOW) && (count_reg <= life_pkg::SURVIVE_HIGH);
        else
            alive = (count_reg == life_pkg::BIRTH_COUNT);
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_rem_next   = col_rem_reg;
        row_rem_next   = row_rem_reg;
        red_cnt_next   = red_cnt_reg;
        live_bit_next  = live_bit_reg;
        rsel_next      = rsel_reg;
        csel_next      = csel_reg;
        rd_valid_next  = 1'b0;
        rd_self_next   = 1'b0;
        count_next     = count_reg;
        self_next      = self_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pixel_next = out_pixel_reg;
        out_alive_next = out_alive_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = {row_reg, col_reg};
        mem_wdata      = live_bit_reg;
        mem_re         = 1'b0;
        mem_raddr      = {row_pick, col_pick};

        // collect the data of the read issued last cycle
        if (rd_valid_reg)
        begin
            if (rd_self_reg)
                self_next = rd_data_reg;
            else
                count_next = count_reg + CNT_W'(rd_data_reg);
        end

        case (state_reg)
            life_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    kind_next     = cmd.kind;
                    col_next      = cmd.col;
                    row_next      = cmd.row;
                    live_bit_next = pix_live;
                    col_rem_next  = '0;
                    row_rem_next  = '0;
                    red_cnt_next  = '0;
                    rsel_next     = '0;
                    csel_next     = '0;
                    count_next    = '0;
                    self_next     = 1'b0;
                    if (!in_range)
                        state_next = life_pkg::ST_REDUCE;
                    else if (cmd.kind == life_pkg::KIND_STORE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {cmd.row, cmd.col};
                        mem_wdata = pix_live;
                    end
                    else
                        state_next = life_pkg::ST_FETCH;
                end
            end

            life_pkg::ST_REDUCE:
            begin
                red_cnt_next = red_cnt_reg + 1'b1;
                if (red_cnt_reg == 3'(POS_W - 1))
                begin
                    // last step: the remainders become the address
                    col_next = col_step;
                    row_next = row_step;
                    state_next = (kind_reg == life_pkg::KIND_STORE) ? life_pkg::ST_WRITE
                                                                    : life_pkg::ST_FETCH;
                end
                else
                begin
                    col_rem_next = col_step;
                    row_rem_next = row_step;
                    col_next     = {col_reg[POS_W-2:0], 1'b0};
                    row_next     = {row_reg[POS_W-2:0], 1'b0};
                end
            end

            life_pkg::ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = life_pkg::ST_IDLE;
            end

            life_pkg::ST_FETCH:
            begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                rd_self_next  = (rsel_reg == 2'd1) && (csel_reg == 2'd1);
                if (csel_reg == 2'd2)
                begin
                    csel_next = '0;
                    rsel_next = rsel_reg + 1'b1;
                    if (rsel_reg == 2'd2)
                        state_next = life_pkg::ST_DRAIN;
                end
                else
                    csel_next = csel_reg + 1'b1;
            end

            life_pkg::ST_DRAIN:
            begin
                state_next = life_pkg::ST_RESULT;
            end

            life_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_alive_next = alive;
                    out_pixel_next = alive ? live_color_reg : dead_color_reg;
                    out_count_next = count_reg;
                    state_next     = life_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = life_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= life_pkg::ST_IDLE;
            rd_valid_reg  <= 1'b0;
            rd_self_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            rd_self_reg   <= rd_self_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        col_rem_reg   <= col_rem_next;
        row_rem_reg   <= row_rem_next;
        red_cnt_reg   <= red_cnt_next;
        live_bit_reg  <= live_bit_next;
        rsel_reg      <= rsel_next;
        csel_reg      <= csel_next;
        count_reg     <= count_next;
        self_reg      <= self_next;
        out_pixel_reg <= out_pixel_next;
        out_alive_reg <= out_alive_next;
        out_count_reg <= out_count_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.next_pixel      = out_pixel_reg;
    assign rsp.next_alive      = out_alive_reg;
    assign rsp.live_neighbours = out_count_reg;

endmodule
`default_nettype wire
